// ===== hw/rtl/irvrl_pkg.sv =====
// irvrl_pkg: shared types and constants of the infrared range linearizer
// command and status structs between controller and datapath, fixed-point constants,
// and the square-root chain table used by the exponential unit; no dependencies
`default_nettype none

package irvrl_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_SLOPE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_INTERCEPT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEV_SLOPE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEV_INTERCEPT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE       = 3'd4;

    localparam logic [23:0] RESET_SLOPE     = 24'd65536;
    localparam logic [15:0] RESET_MAX_RANGE = 16'd8000;

    // ln 2 and log2 e in Q30
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

    localparam logic [31:0] DEV_ONE = 32'h0001_0000;

    // iteration counts
    localparam logic [5:0] LN_STEPS  = 6'd16;
    localparam logic [5:0] DIV_STEPS = 6'd41;
    localparam logic [5:0] EXP_STEPS = 6'd16;

    typedef logic [31:0] root_tab_t [16];

    // c(0) = 2.0 in Q30, c(i) = isqrt(c(i-1) * 2^30): successive square roots of two
    function automatic root_tab_t exp_root_table();
        root_tab_t   tab;
        logic [63:0] c;
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        c = 64'd2 << 30;
        for (int i = 0; i < 16; i++)
        begin
            n = c << 30;
            r = 64'd0;
            b = 64'd1 << 62;
            for (int j = 0; j < 32; j++)
            begin
                if (n >= r + b)
                begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            c = r;
            tab[i] = c[31:0];
        end
        return tab;
    endfunction

    typedef struct packed {
        logic load;
        logic ln_init;
        logic ln_sel_dev;
        logic ln_step;
        logic ln_fin;
        logic div_init;
        logic div_step;
        logic exp_load;
        logic exp_sel_dev;
        logic exp_mul;
        logic exp_step;
        logic exp_scale;
        logic range_fin;
        logic check;
        logic dev_mul;
        logic dev_fin;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic nr_zero;
        logic in_range;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/irvrl_ctrl.sv =====
// irvrl_ctrl: sequencer of the linearizer, one-hot state machine and step counter
// depends on irvrl_pkg for the command and status structs
`default_nettype none

module irvrl_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire irvrl_pkg::status_t st,
    output irvrl_pkg::cmd_t         cmd
);

    typedef enum logic [15:0] {
        S_IDLE      = 16'h0001,
        S_DECIDE    = 16'h0002,
        S_LN_INIT   = 16'h0004,
        S_LN_SQ     = 16'h0008,
        S_LN_FIN    = 16'h0010,
        S_DIV_INIT  = 16'h0020,
        S_DIV       = 16'h0040,
        S_EXP_LOAD  = 16'h0080,
        S_EXP_MUL   = 16'h0100,
        S_EXP_STEP  = 16'h0200,
        S_EXP_SCALE = 16'h0400,
        S_RANGE_FIN = 16'h0800,
        S_CHECK     = 16'h1000,
        S_DEV_MUL   = 16'h2000,
        S_DEV_FIN   = 16'h4000,
        S_OUT       = 16'h8000
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       phase_dev_reg, phase_dev_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= 6'd0;
            phase_dev_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            phase_dev_reg <= phase_dev_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        phase_dev_next = phase_dev_reg;
        cmd            = '0;
        cmd.ln_sel_dev  = phase_dev_reg;
        cmd.exp_sel_dev = phase_dev_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load       = 1'b1;
                    phase_dev_next = 1'b0;
                    state_next     = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                // reported range of zero asks for the voltage conversion
                state_next = st.nr_zero ? S_LN_INIT : S_CHECK;
            end
            S_LN_INIT:
            begin
                cmd.ln_init = 1'b1;
                state_next  = S_LN_SQ;
            end
            S_LN_SQ:
            begin
                cmd.ln_step = 1'b1;
                if (cnt_reg == irvrl_pkg::LN_STEPS - 6'd1)
                begin
                    cnt_next   = 6'd0;
                    state_next = S_LN_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            S_LN_FIN:
            begin
                cmd.ln_fin = 1'b1;
                state_next = phase_dev_reg ? S_DEV_MUL : S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == irvrl_pkg::DIV_STEPS - 6'd1)
                begin
                    cnt_next   = 6'd0;
                    state_next = S_EXP_LOAD;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            S_EXP_LOAD:
            begin
                cmd.exp_load = 1'b1;
                state_next   = S_EXP_MUL;
            end
            S_EXP_MUL:
            begin
                cmd.exp_mul = 1'b1;
                state_next  = S_EXP_STEP;
            end
            S_EXP_STEP:
            begin
                cmd.exp_step = 1'b1;
                if (cnt_reg == irvrl_pkg::EXP_STEPS - 6'd1)
                begin
                    cnt_next   = 6'd0;
                    state_next = S_EXP_SCALE;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            S_EXP_SCALE:
            begin
                cmd.exp_scale = 1'b1;
                state_next    = phase_dev_reg ? S_DEV_FIN : S_RANGE_FIN;
            end
            S_RANGE_FIN:
            begin
                cmd.range_fin = 1'b1;
                state_next    = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                if (st.in_range && !st.nr_zero)
                begin
                    phase_dev_next = 1'b1;
                    state_next     = S_LN_INIT;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_DEV_MUL:
            begin
                cmd.dev_mul = 1'b1;
                state_next  = S_EXP_LOAD;
            end
            S_DEV_FIN:
            begin
                cmd.dev_fin = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/irvrl_dpath.sv =====
// irvrl_dpath: datapath of the linearizer: config registers, log unit, divider,
// exponential unit, held range and output register; depends on irvrl_pkg
`default_nettype none

module irvrl_dpath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire irvrl_pkg::cmd_t                  cmd,
    output irvrl_pkg::status_t                    st,
    input  wire logic [15:0]                      voltage,
    input  wire logic [15:0]                      reported_range,
    input  wire logic                             cfg_valid,
    input  wire logic [irvrl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [23:0]                      cfg_data,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [15:0]                           range_mm,
    output logic [31:0]                           deviation,
    output logic                                  too_far
);

    localparam irvrl_pkg::root_tab_t ROOT_C = irvrl_pkg::exp_root_table();

    // configuration
    logic signed [23:0] rs_reg, ri_reg, ds_reg, di_reg;
    logic [15:0]        mx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_reg <= irvrl_pkg::RESET_SLOPE;
            ri_reg <= 24'sd0;
            ds_reg <= irvrl_pkg::RESET_SLOPE;
            di_reg <= 24'sd0;
            mx_reg <= irvrl_pkg::RESET_MAX_RANGE;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                irvrl_pkg::REG_RANGE_SLOPE:     rs_reg <= cfg_data;
                irvrl_pkg::REG_RANGE_INTERCEPT: ri_reg <= cfg_data;
                irvrl_pkg::REG_DEV_SLOPE:       ds_reg <= cfg_data;
                irvrl_pkg::REG_DEV_INTERCEPT:   di_reg <= cfg_data;
                irvrl_pkg::REG_MAX_RANGE:       mx_reg <= cfg_data[15:0];
                default:                        ;
            endcase
        end
    end

    // sample and result state
    logic [15:0] v_reg, nr_reg;
    logic [15:0] held_reg;
    logic [31:0] dev_reg;
    logic        far_reg;

    // log unit
    logic [30:0] mant_reg;
    logic [3:0]  lgk_reg;
    logic [15:0] lgf_reg;
    logic [19:0] ln_reg;

    // divider
    logic [40:0] dnum_reg;
    logic [23:0] drem_reg;
    logic [23:0] dden_reg;
    logic        dneg_reg;

    // exponential unit
    logic signed [29:0] dev_e_reg;
    logic signed [22:0] t_reg;
    logic signed [7:0]  k_reg;
    logic [15:0]        f_reg;
    logic [3:0]         idx_reg;
    logic [30:0]        p_reg;
    logic [48:0]        exp_reg;

    // output register
    logic        out_valid_reg;
    logic [15:0] out_range_reg;
    logic [31:0] out_dev_reg;
    logic        out_far_reg;

    assign st.nr_zero  = (nr_reg == 16'd0);
    assign st.in_range = (nr_reg <= mx_reg);
    assign st.out_free = !out_valid_reg || !out_stall;

    // log: leading one and initial mantissa
    logic [15:0] ln_x;
    logic [3:0]  ln_k;
    logic [30:0] ln_mant0;
    always_comb
    begin
        ln_x = cmd.ln_sel_dev ? nr_reg : v_reg;
        ln_k = 4'd0;
        for (int i = 1; i < 16; i++)
        begin
            if (ln_x[i])
                ln_k = 4'(i);
        end
        ln_mant0 = 31'(ln_x) << (5'd30 - {1'b0, ln_k});
    end

    logic [61:0] ln_sq;
    logic [31:0] ln_m2;
    logic [49:0] ln_prod;
    logic [50:0] ln_rnd;
    assign ln_sq   = mant_reg * mant_reg;
    assign ln_m2   = ln_sq[61:30];
    assign ln_prod = {lgk_reg, lgf_reg} * irvrl_pkg::LN2_Q30;
    assign ln_rnd  = {1'b0, ln_prod} + (51'd1 << 29);

    // divider setup and step
    logic signed [24:0] div_diff;
    logic [24:0]        div_mag;
    logic [23:0]        div_den;
    logic [24:0]        div_trial;
    logic               div_q;
    assign div_diff  = $signed({5'b0, ln_reg}) - 25'(ri_reg);
    assign div_mag   = div_diff[24] ? 25'(-div_diff) : 25'(div_diff);
    assign div_den   = rs_reg[23] ? 24'(-rs_reg) : 24'(rs_reg);
    assign div_trial = {drem_reg, dnum_reg[40]};
    assign div_q     = (div_trial >= {1'b0, dden_reg});

    // exponent sources, clamped to +-32.0
    logic [21:0]        q_clamp;
    logic signed [22:0] t_div, t_dev;
    always_comb
    begin
        q_clamp = (dnum_reg > 41'd2097152) ? 22'd2097152 : dnum_reg[21:0];
        t_div   = dneg_reg ? -$signed({1'b0, q_clamp}) : $signed({1'b0, q_clamp});
        if (dev_e_reg > 30'sd2097152)
            t_dev = 23'sd2097152;
        else if (dev_e_reg < -30'sd2097152)
            t_dev = -23'sd2097152;
        else
            t_dev = dev_e_reg[22:0];
    end

    logic signed [44:0] dev_prod;
    logic signed [29:0] dev_e;
    assign dev_prod = $signed({1'b0, ln_reg}) * ds_reg;
    assign dev_e    = 30'($signed(dev_prod[44:16])) + 30'(di_reg);

    logic signed [54:0] exp_y;
    logic [62:0]        exp_pc;
    assign exp_y  = t_reg * $signed({1'b0, irvrl_pkg::LOG2E_Q30});
    assign exp_pc = p_reg * ROOT_C[idx_reg];

    // scaling by 2^k: saturation, left shifts, rounded right shifts or zero for large right shifts
    logic signed [8:0] sc_s;
    logic [4:0]        sc_l;
    logic [31:0]       sc_sum;
    logic [48:0]       sc_res;
    always_comb
    begin
        sc_s   = 9'sd14 - 9'(k_reg);
        sc_l   = 5'(k_reg - 8'sd14);
        sc_sum = {1'b0, p_reg} + (32'd1 << (sc_s[4:0] - 5'd1));
        if (k_reg >= 8'sd33)
            sc_res = 49'd1 << 48;
        else if (k_reg >= 8'sd14)
            sc_res = 49'(p_reg) << sc_l;
        else if (sc_s > 9'sd31)
            sc_res = 49'd0;
        else
            sc_res = 49'(sc_sum >> sc_s[4:0]);
    end

    logic [48:0] rng_rnd;
    assign rng_rnd = exp_reg + 49'h8000;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            v_reg <= voltage;
            if (reported_range == 16'd0 && (voltage == 16'd0 || rs_reg == 24'sd0))
                nr_reg <= 16'hFFFF;
            else
                nr_reg <= reported_range;
        end
        else if (cmd.range_fin)
        begin
            nr_reg <= (rng_rnd[48:32] != 17'd0) ? 16'hFFFF : rng_rnd[31:16];
        end

        if (cmd.ln_init)
        begin
            mant_reg <= ln_mant0;
            lgk_reg  <= ln_k;
            lgf_reg  <= 16'd0;
        end
        else if (cmd.ln_step)
        begin
            mant_reg <= ln_m2[31] ? ln_m2[31:1] : ln_m2[30:0];
            lgf_reg  <= {lgf_reg[14:0], ln_m2[31]};
        end
        if (cmd.ln_fin)
            ln_reg <= ln_rnd[49:30];

        if (cmd.div_init)
        begin
            dnum_reg <= {div_mag, 16'd0};
            drem_reg <= 24'd0;
            dden_reg <= div_den;
            dneg_reg <= div_diff[24] ^ rs_reg[23];
        end
        else if (cmd.div_step)
        begin
            drem_reg <= div_q ? 24'(div_trial - {1'b0, dden_reg}) : div_trial[23:0];
            dnum_reg <= {dnum_reg[39:0], div_q};
        end

        if (cmd.dev_mul)
            dev_e_reg <= dev_e;
        if (cmd.exp_load)
            t_reg <= cmd.exp_sel_dev ? t_dev : t_div;
        if (cmd.exp_mul)
        begin
            k_reg   <= exp_y[53:46];
            f_reg   <= exp_y[45:30];
            idx_reg <= 4'd0;
            p_reg   <= 31'd1 << 30;
        end
        else if (cmd.exp_step)
        begin
            if (f_reg[15])
                p_reg <= exp_pc[60:30];
            f_reg   <= {f_reg[14:0], 1'b0};
            idx_reg <= idx_reg + 4'd1;
        end
        if (cmd.exp_scale)
            exp_reg <= sc_res;

        if (cmd.check)
        begin
            if (st.in_range)
            begin
                far_reg <= 1'b0;
                if (st.nr_zero)
                    dev_reg <= 32'd0;
            end
            else
            begin
                far_reg <= 1'b1;
                dev_reg <= irvrl_pkg::DEV_ONE;
            end
        end
        else if (cmd.dev_fin)
        begin
            dev_reg <= (exp_reg[48:32] != 17'd0) ? 32'hFFFF_FFFF : exp_reg[31:0];
        end

        if (cmd.out_load)
        begin
            out_range_reg <= held_reg;
            out_dev_reg   <= dev_reg;
            out_far_reg   <= far_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.check && st.in_range)
                held_reg <= nr_reg;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign range_mm  = out_range_reg;
    assign deviation = out_dev_reg;
    assign too_far   = out_far_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ir_voltage_to_range_linearizer_top.sv =====
// ir_voltage_to_range_linearizer_top: one infrared range channel linearizer
// joins irvrl_ctrl and irvrl_dpath; depends on irvrl_pkg
//
//   channel | handshake             | payload
//   in      | in_valid / in_stall   | voltage, reported_range
//   out     | out_valid / out_stall | range_mm, deviation, too_far
//   cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one sample at a time; a nonzero reported range skips the voltage conversion, and a nonzero
// range within the limit adds the deviation exponential; the voltage conversion runs the log
// unit, the divider and the exponential unit (16 log squarings, 41 divider steps and 16
// exponential products per pass, each one step a cycle on a shared unit)
// in_stall is high from accept until the result is loaded into the output register
// a stalled result holds the sequencer before the output load; reset is asynchronous
`default_nettype none

module ir_voltage_to_range_linearizer_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [15:0]                     voltage,
    input  wire logic [15:0]                     reported_range,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [15:0]                          range_mm,
    output logic [31:0]                          deviation,
    output logic                                 too_far,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [irvrl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [23:0]                     cfg_data
);

    irvrl_pkg::cmd_t    cmd;
    irvrl_pkg::status_t st;

    assign cfg_ready = 1'b1;

    irvrl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    irvrl_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .voltage        (voltage),
        .reported_range (reported_range),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .range_mm       (range_mm),
        .deviation      (deviation),
        .too_far        (too_far)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/irvrl_checker.sv =====
// irvrl_checker: port-level assertions for the linearizer top, bound to it below
// depends on irvrl_pkg and ir_voltage_to_range_linearizer_top
`default_nettype none

module irvrl_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_stall,
    input wire logic [15:0]                     voltage,
    input wire logic [15:0]                     reported_range,
    input wire logic                            out_valid,
    input wire logic                            out_stall,
    input wire logic [15:0]                     range_mm,
    input wire logic [31:0]                     deviation,
    input wire logic                            too_far,
    input wire logic                            cfg_valid,
    input wire logic                            cfg_ready,
    input wire logic [irvrl_pkg::CFG_IDX_W-1:0] cfg_index,
    input wire logic [23:0]                     cfg_data
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(range_mm)
            && $stable(deviation) && $stable(too_far))
        else $error("stalled result changed");

    // an ignored range always reports unit deviation
    a_far_dev: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && too_far |-> deviation == irvrl_pkg::DEV_ONE)
        else $error("too_far without unit deviation");

    // an accepted range of zero gives zero deviation
    a_zero_dev: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !too_far && range_mm == 16'd0 |-> deviation == 32'd0)
        else $error("zero range with nonzero deviation");

    // one sample at a time: busy right after an accepted sample
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted twice in a row");

endmodule

bind ir_voltage_to_range_linearizer_top irvrl_checker u_irvrl_checker (.*);

`default_nettype wire

// ===== test/ir_voltage_to_range_linearizer_top_tb.sv =====
// testbench for the infrared range linearizer: random and corner samples checked against
// an in-bench fixed-point predictor through a small scoreboard class
// depends on irvrl_pkg and ir_voltage_to_range_linearizer_top
`default_nettype none

module ir_voltage_to_range_linearizer_top_tb;

    typedef struct packed {
        logic [15:0] range_mm;
        logic [31:0] deviation;
        logic        too_far;
    } reading_t;

    // predictor of the linearizer with its own register copy
    class range_scoreboard;
        logic [23:0] r_slope;
        logic [23:0] r_icpt;
        logic [23:0] d_slope;
        logic [23:0] d_icpt;
        logic [15:0] limit_mm;
        logic [15:0] held_mm;
        reading_t    pending[$];
        int          n_fail;
        int          n_checked;
        int          n_far;
        int          n_computed;

        function void clear();
            r_slope = irvrl_pkg::RESET_SLOPE;
            r_icpt = '0;
            d_slope = irvrl_pkg::RESET_SLOPE;
            d_icpt = '0;
            limit_mm = irvrl_pkg::RESET_MAX_RANGE;
            held_mm = '0;
            pending.delete();
            n_fail = 0;
            n_checked = 0;
            n_far = 0;
            n_computed = 0;
        endfunction

        function void write_reg(logic [irvrl_pkg::CFG_IDX_W-1:0] idx, logic [23:0] val);
            case (idx)
                irvrl_pkg::REG_RANGE_SLOPE:     r_slope = val;
                irvrl_pkg::REG_RANGE_INTERCEPT: r_icpt = val;
                irvrl_pkg::REG_DEV_SLOPE:       d_slope = val;
                irvrl_pkg::REG_DEV_INTERCEPT:   d_icpt = val;
                irvrl_pkg::REG_MAX_RANGE:       limit_mm = val[15:0];
                default: ;
            endcase
        endfunction

        static function longint floor_sh(longint x, int s);
            return x >>> s;
        endfunction

        static function longint unsigned root64(longint unsigned n);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n)
                b = b >> 2;
            while (b != 0)
            begin
                if (n >= r + b)
                begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        static function longint log_nat(logic [15:0] x);
            int unsigned     k;
            longint unsigned mant;
            longint unsigned lg;
            k = 0;
            while (k < 15 && (x >> (k + 1)) != 0)
                k++;
            mant = 64'(x) << (30 - k);
            lg = 64'(k) << 16;
            for (int i = 0; i < 16; i++)
            begin
                mant = (mant * mant) >> 30;
                if (mant >= (64'd2 << 30))
                begin
                    lg = lg | (64'd1 << (15 - i));
                    mant = mant >> 1;
                end
            end
            return longint'((lg * 64'd744261118 + (64'd1 << 29)) >> 30);
        endfunction

        static function longint unsigned exp_fix(longint t);
            longint          y;
            longint          k;
            longint          s;
            longint unsigned f;
            longint unsigned p;
            longint unsigned c;
            p = 64'd1 << 30;
            c = 64'd2 << 30;
            if (t > 64'sd2097152)
                t = 64'sd2097152;
            if (t < -64'sd2097152)
                t = -64'sd2097152;
            y = floor_sh(t * 64'sd1549082005, 30);
            k = floor_sh(y, 16);
            f = y & 64'hFFFF;
            for (int i = 0; i < 16; i++)
            begin
                c = root64(c << 30);
                if ((f >> (15 - i)) & 1)
                    p = (p * c) >> 30;
            end
            if (k >= 33)
                return 64'd1 << 48;
            if (k >= 14)
                return p << (k - 14);
            s = 14 - k;
            if (s >= 62)
                return 0;
            return (p + (64'd1 << (s - 1))) >> s;
        endfunction

        function void note_sample(logic [15:0] volts, logic [15:0] reported);
            reading_t        exp_r;
            logic [15:0]     nr;
            longint          m;
            longint          q;
            longint          e;
            longint unsigned r;
            longint unsigned dv;
            nr = reported;
            m = longint'($signed(r_slope));
            exp_r.too_far = 1'b0;
            if (nr == 0)
            begin
                n_computed++;
                if (volts == 0 || m == 0)
                    nr = 16'hFFFF;
                else
                begin
                    q = ((log_nat(volts) - longint'($signed(r_icpt))) * 65536) / m;
                    r = (exp_fix(q) + 64'h8000) >> 16;
                    nr = (r > 64'hFFFF) ? 16'hFFFF : r[15:0];
                end
            end
            if (nr <= limit_mm)
            begin
                held_mm = nr;
                if (nr == 0)
                    dv = 0;
                else
                begin
                    e = floor_sh(log_nat(nr) * longint'($signed(d_slope)), 16)
                        + longint'($signed(d_icpt));
                    dv = exp_fix(e);
                    if (dv > 64'hFFFF_FFFF)
                        dv = 64'hFFFF_FFFF;
                end
            end
            else
            begin
                dv = irvrl_pkg::DEV_ONE;
                exp_r.too_far = 1'b1;
                n_far++;
            end
            exp_r.range_mm = held_mm;
            exp_r.deviation = dv[31:0];
            pending.push_back(exp_r);
        endfunction

        function void check_reading(reading_t got);
            reading_t want;
            if (pending.size() == 0)
            begin
                $error("result with no sample outstanding");
                n_fail++;
                return;
            end
            want = pending.pop_front();
            n_checked++;
            if (got.range_mm !== want.range_mm)
            begin
                $error("range_mm expected %0d got %0d", want.range_mm, got.range_mm);
                n_fail++;
            end
            if (got.deviation !== want.deviation)
            begin
                $error("deviation expected %h got %h", want.deviation, got.deviation);
                n_fail++;
            end
            if (got.too_far !== want.too_far)
            begin
                $error("too_far expected %0d got %0d", want.too_far, got.too_far);
                n_fail++;
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic [15:0]                     voltage;
    logic [15:0]                     reported_range;
    logic                            out_valid;
    logic                            out_stall;
    logic [15:0]                     range_mm;
    logic [31:0]                     deviation;
    logic                            too_far;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [irvrl_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [23:0]                     cfg_data;

    range_scoreboard sb;
    longint          cycles;
    bit              rx_random;
    int              stall_left;

    localparam longint CYCLE_LIMIT = 3000000;

    ir_voltage_to_range_linearizer_top uut (.*);

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int gap_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 3);
    endfunction

    // receiver: check on accept, stall randomly at the falling edge
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && out_valid && !out_stall)
            sb.check_reading('{range_mm, deviation, too_far});
    end

    always @(negedge clk)
    begin
        if (!rst_n || !rx_random)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= gap_len();
        end
        else
            out_stall <= 1'b0;
    end

    // valid stays high into the next sample when there is no gap
    task automatic send_sample(logic [15:0] v, logic [15:0] rr);
        int n;
        n = gap_len() * (rx_random ? 1 : 0);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        voltage <= v;
        reported_range <= rr;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_sample(v, rr);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_cfg(logic [irvrl_pkg::CFG_IDX_W-1:0] idx, logic [23:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // plausible coefficient values with occasional extremes
    function automatic logic [23:0] coef(bit slope);
        case ($urandom_range(0, 9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return slope ? 24'h0 : 24'h1;
            default: return slope ? 24'($signed($urandom_range(0, 196608)) - 98304)
                                  : 24'($signed($urandom_range(0, 1048576)) - 524288);
        endcase
    endfunction

    function automatic logic [15:0] rand_range();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'hFFFF;
            default: return 16'($urandom_range(1, 12000));
        endcase
    endfunction

    always @(posedge clk)
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end

    initial
    begin
        sb = new();
        sb.clear();
        rx_random = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        voltage = '0;
        reported_range = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // directed: reset coefficients, extremes and special cases
        send_sample(16'd0, 16'd0);
        send_sample(16'hFFFF, 16'd0);
        send_sample(16'd1, 16'd0);
        send_sample(16'd3000, 16'd0);
        send_sample(16'd100, 16'd1);
        send_sample(16'd0, 16'd8000);
        send_sample(16'd0, 16'd8001);
        send_sample(16'd0, 16'hFFFF);
        send_sample(16'h5555, 16'hAAAA);
        drain();
        write_cfg(irvrl_pkg::REG_RANGE_SLOPE, 24'h0);
        write_cfg(irvrl_pkg::REG_MAX_RANGE, 24'hFFFF);
        send_sample(16'd500, 16'd0);
        send_sample(16'd0, 16'hFFFF);
        drain();
        write_cfg(irvrl_pkg::REG_RANGE_SLOPE, 24'hFF0000);
        write_cfg(irvrl_pkg::REG_RANGE_INTERCEPT, 24'h7FFFFF);
        write_cfg(irvrl_pkg::REG_DEV_SLOPE, 24'h7FFFFF);
        write_cfg(irvrl_pkg::REG_DEV_INTERCEPT, 24'h7FFFFF);
        send_sample(16'd2000, 16'd0);
        send_sample(16'd0, 16'd2);
        drain();
        write_cfg(irvrl_pkg::REG_RANGE_SLOPE, 24'h800000);
        write_cfg(irvrl_pkg::REG_RANGE_INTERCEPT, 24'h800000);
        write_cfg(irvrl_pkg::REG_DEV_SLOPE, 24'h800000);
        write_cfg(irvrl_pkg::REG_DEV_INTERCEPT, 24'h800000);
        write_cfg(irvrl_pkg::REG_MAX_RANGE, 24'h0);
        send_sample(16'd40000, 16'd0);
        send_sample(16'd0, 16'd5);
        send_sample(16'd7, 16'd0);
        drain();
        write_cfg(3'd7, 24'h123456);
        write_cfg(irvrl_pkg::REG_MAX_RANGE, 24'd8000);

        // random phases, each with fresh coefficients
        rx_random = 1'b1;
        for (int ph = 0; ph < 17; ph++)
        begin
            drain();
            write_cfg(irvrl_pkg::REG_RANGE_SLOPE, coef(1));
            write_cfg(irvrl_pkg::REG_RANGE_INTERCEPT, coef(0));
            write_cfg(irvrl_pkg::REG_DEV_SLOPE, coef(1));
            write_cfg(irvrl_pkg::REG_DEV_INTERCEPT, coef(0));
            write_cfg(irvrl_pkg::REG_MAX_RANGE,
                      ($urandom_range(0, 7) == 0) ? 24'($urandom_range(0, 65535))
                                                  : 24'($urandom_range(500, 12000)));
            for (int i = 0; i < 100; i++)
            begin
                // hold off until the block is empty now and then
                if (i == 50)
                begin
                    in_valid <= 1'b0;
                    while (sb.pending.size() != 0)
                        @(negedge clk);
                end
                send_sample(16'($urandom_range(0, 65535)),
                            $urandom_range(0, 1) ? 16'd0 : rand_range());
            end
        end

        drain();
        $display("checked %0d results, %0d computed from voltage, %0d beyond the limit",
                 sb.n_checked, sb.n_computed, sb.n_far);
        if (sb.n_fail == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
